// ===== rtl/core/aat_pkg.sv =====
package aat_pkg;

  // Signed Q16.16 coordinate or coefficient.
  typedef logic signed [31:0] coord_t;
  // Full product of two Q16.16 values (Q32.32).
  typedef logic signed [63:0] prod_t;
  // Sum of three products plus a translation aligned to Q32.32, kept exact.
  typedef logic signed [66:0] acc_t;
  // One 64-bit configuration register.
  typedef logic [63:0] reg_word_t;

  localparam int NUM_AXES  = 3;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z_HI = 3'd5;

  // Reset values give the identity transform.
  localparam reg_word_t RST_ROW_X_LO = 64'h0000_0000_0001_0000;
  localparam reg_word_t RST_ROW_X_HI = 64'h0000_0000_0000_0000;
  localparam reg_word_t RST_ROW_Y_LO = 64'h0001_0000_0000_0000;
  localparam reg_word_t RST_ROW_Y_HI = 64'h0000_0000_0000_0000;
  localparam reg_word_t RST_ROW_Z_LO = 64'h0000_0000_0000_0000;
  localparam reg_word_t RST_ROW_Z_HI = 64'h0000_0000_0001_0000;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/core/aabb_affine_transform.sv =====
// Bounds an axis-aligned box after the affine transform held in the six
// configuration registers. One box is taken on every clock at which start is
// high; busy is always low, so the block never refuses an item. Each result is
// shown for one cycle with out_valid high. The receiver cannot stall it. The
// result comes through five register stages: input, products, per-term
// min/max, sums, and the floored and saturated output. Every stage takes a
// new item on every clock, so one box per clock gets through. The multiply
// stage has eighteen 32x32 signed multipliers working side by side (both
// corners against every coefficient). The per-axis minimum and maximum are
// built term by term, then summed with the translation, floored by 16 bits
// and saturated to 32 bits.
// Write the registers only while no item is in flight.
module aabb_affine_transform
  import aat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  // Input items
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_lo_x,
  input  logic signed [31:0]   in_lo_y,
  input  logic signed [31:0]   in_lo_z,
  input  logic signed [31:0]   in_hi_x,
  input  logic signed [31:0]   in_hi_y,
  input  logic signed [31:0]   in_hi_z,
  // Result items
  output logic                 out_valid,
  output logic signed [31:0]   out_lo_x,
  output logic signed [31:0]   out_lo_y,
  output logic signed [31:0]   out_lo_z,
  output logic signed [31:0]   out_hi_x,
  output logic signed [31:0]   out_hi_y,
  output logic signed [31:0]   out_hi_z
);

  reg_word_t row_r [NUM_REGS];

  logic   in_vld_r, prod_vld_r, mm_vld_r, sum_vld_r, out_vld_r;

  coord_t lo_r [NUM_AXES];
  coord_t hi_r [NUM_AXES];

  coord_t coef   [NUM_AXES][NUM_AXES];
  coord_t trans  [NUM_AXES];

  prod_t  plo_nxt [NUM_AXES][NUM_AXES];
  prod_t  phi_nxt [NUM_AXES][NUM_AXES];
  prod_t  plo_r   [NUM_AXES][NUM_AXES];
  prod_t  phi_r   [NUM_AXES][NUM_AXES];

  prod_t  pmin_nxt [NUM_AXES][NUM_AXES];
  prod_t  pmax_nxt [NUM_AXES][NUM_AXES];
  prod_t  pmin_r   [NUM_AXES][NUM_AXES];
  prod_t  pmax_r   [NUM_AXES][NUM_AXES];

  acc_t   smin_nxt [NUM_AXES];
  acc_t   smax_nxt [NUM_AXES];
  acc_t   smin_r   [NUM_AXES];
  acc_t   smax_r   [NUM_AXES];

  coord_t omin_nxt [NUM_AXES];
  coord_t omax_nxt [NUM_AXES];
  coord_t omin_r   [NUM_AXES];
  coord_t omax_r   [NUM_AXES];

  logic   accept;

  // Every cycle can take an item.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= RST_ROW_X_LO;
      row_r[1] <= RST_ROW_X_HI;
      row_r[2] <= RST_ROW_Y_LO;
      row_r[3] <= RST_ROW_Y_HI;
      row_r[4] <= RST_ROW_Z_LO;
      row_r[5] <= RST_ROW_Z_HI;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X_LO: row_r[0] <= cfg_data;
        REG_ROW_X_HI: row_r[1] <= cfg_data;
        REG_ROW_Y_LO: row_r[2] <= cfg_data;
        REG_ROW_Y_HI: row_r[3] <= cfg_data;
        REG_ROW_Z_LO: row_r[4] <= cfg_data;
        REG_ROW_Z_HI: row_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the matrix rows into coefficients and translations.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      coef[a][0] = row_r[2*a][31:0];
      coef[a][1] = row_r[2*a][63:32];
      coef[a][2] = row_r[2*a+1][31:0];
      trans[a]   = row_r[2*a+1][63:32];
    end
  end

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      mm_vld_r   <= 1'b0;
      sum_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      in_vld_r   <= accept;
      prod_vld_r <= in_vld_r;
      mm_vld_r   <= prod_vld_r;
      sum_vld_r  <= mm_vld_r;
      out_vld_r  <= sum_vld_r;
    end
  end

  // Products of each coefficient with both corner values of its input axis.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        plo_nxt[a][j] = prod_t'(coef[a][j]) * prod_t'(lo_r[j]);
        phi_nxt[a][j] = prod_t'(coef[a][j]) * prod_t'(hi_r[j]);
      end
    end
  end

  // Each term is picked independently, which spans all eight corners.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        if (plo_r[a][j] < phi_r[a][j]) begin
          pmin_nxt[a][j] = plo_r[a][j];
          pmax_nxt[a][j] = phi_r[a][j];
        end else begin
          pmin_nxt[a][j] = phi_r[a][j];
          pmax_nxt[a][j] = plo_r[a][j];
        end
      end
    end
  end

  // Exact sums with the translation aligned to the product's binary point.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      smin_nxt[a] = acc_t'(pmin_r[a][0]) + acc_t'(pmin_r[a][1]) + acc_t'(pmin_r[a][2])
                    + (acc_t'(trans[a]) <<< FRAC_BITS);
      smax_nxt[a] = acc_t'(pmax_r[a][0]) + acc_t'(pmax_r[a][1]) + acc_t'(pmax_r[a][2])
                    + (acc_t'(trans[a]) <<< FRAC_BITS);
    end
  end

  // Floor by dropping the low 16 fraction bits, then saturate to 32 bits.
  function automatic coord_t floor_sat(acc_t s);
    logic fits;
    fits = (&s[66:47]) || !(|s[66:47]);
    if (fits) begin
      return s[47:16];
    end else if (s[66]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      omin_nxt[a] = floor_sat(smin_r[a]);
      omax_nxt[a] = floor_sat(smax_r[a]);
    end
  end

  // Payload registers along the pipeline.
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_r[0] <= in_lo_x;
      lo_r[1] <= in_lo_y;
      lo_r[2] <= in_lo_z;
      hi_r[0] <= in_hi_x;
      hi_r[1] <= in_hi_y;
      hi_r[2] <= in_hi_z;
    end
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    pmin_r <= pmin_nxt;
    pmax_r <= pmax_nxt;
    smin_r <= smin_nxt;
    smax_r <= smax_nxt;
    omin_r <= omin_nxt;
    omax_r <= omax_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_lo_x  = omin_r[0];
  assign out_lo_y  = omin_r[1];
  assign out_lo_z  = omin_r[2];
  assign out_hi_x  = omax_r[0];
  assign out_hi_y  = omax_r[1];
  assign out_hi_z  = omax_r[2];

`ifndef SYNTH
  // An accepted item always gets its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("result strobe missing five clocks after an accepted item");

  // No result appears without a matching accepted item.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result strobe without a matching item");

  // Minimum over the corners never exceeds the maximum.
  a_order_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lo_x <= out_hi_x)
    else $error("x bound minimum above maximum");

  a_order_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lo_y <= out_hi_y)
    else $error("y bound minimum above maximum");

  a_order_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lo_z <= out_hi_z)
    else $error("z bound minimum above maximum");
`endif

endmodule
